// ===== src/rds_pkg.sv =====
// Rectangle divider search: shared constants and types.
// Depends on nothing; imported by rds_div, the top level and the testbench.
`default_nettype none

package rds_pkg;

    // Bits of the byte count that take part in the search.
    localparam int COUNT_BITS = 32;
    // Datapath width: the port carries 32 bits, so never wider than that.
    localparam int CNT_W      = (COUNT_BITS < 32) ? COUNT_BITS : 32;
    // Floor root of a CNT_W-bit value fits in ROOT_W bits.
    localparam int ROOT_W     = (CNT_W + 1) / 2;
    // Highest even bit position used by the digit-by-digit root.
    localparam int ROOT_TOP   = 2 * ROOT_W - 2;
    // Step counter of the divider must hold CNT_W itself.
    localparam int DIV_CNT_W  = $clog2(CNT_W + 1);

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] quotient;
        logic [CNT_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== src/rds_if.sv =====
// Word channels of the rectangle divider search: request and response.
// Depends on rds_pkg for nothing but sits after it in compile order.
`default_nettype none

interface rds_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] byte_count;
    logic [6:0]  transfer_bytes;

    modport source (output valid, output byte_count, output transfer_bytes, input ready);
    modport sink   (input valid, input byte_count, input transfer_bytes, output ready);
endinterface

interface rds_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] row_width;
    logic [31:0] row_count;
    logic        found;

    modport source (output valid, output row_width, output row_count, output found,
                    input ready);
    modport sink   (input valid, input row_width, input row_count, input found,
                    output ready);
endinterface

`default_nettype wire

// ===== src/rds_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle, shared by the search.
// Depends on rds_pkg (widths, request and response structs).
`default_nettype none

module rds_div
    import rds_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg,    busy_next;
    logic                 done_reg,    done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,     cnt_next;
    logic [CNT_W-1:0]     rem_reg,     rem_next;
    logic [CNT_W-1:0]     quo_reg,     quo_next;
    logic [CNT_W-1:0]     divisor_reg, divisor_next;

    logic [CNT_W:0]       trial;
    logic                 fits;

    always_comb
    begin
        trial        = {rem_reg, quo_reg[CNT_W-1]};
        fits         = (trial >= {1'b0, divisor_reg});
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start && !busy_reg)
        begin
            busy_next    = 1'b1;
            cnt_next     = DIV_CNT_W'(CNT_W);
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the top trial bit drops out
            rem_next = fits ? CNT_W'(trial - {1'b0, divisor_reg}) : trial[CNT_W-1:0];
            quo_next = {quo_reg[CNT_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// ===== src/dma_rectangle_divider_search.sv =====
// Top level of the rectangle divider search.
// Depends on rds_pkg, rds_if (word channels) and rds_div (shared divider).
`default_nettype none

// Takes one request word (byte_count, transfer_bytes) at a time and returns
// one response word: the largest row_width not above floor(sqrt(count)) that
// divides the count exactly, row_count = count / row_width, and found. A
// transfer_bytes of zero selects default_transfer_bytes (written through
// cfg_we / cfg_wdata, reset value 16). A count that is zero, or not a multiple
// of the effective transfer size, or an effective size of zero, gives found = 0
// with both other fields 0. req.ready is high only while no request is in work.
// Every division goes through one shared radix-2 divider. A request costs one
// divide for the multiple test, a bit-serial floor root over ROOT_W digits,
// then one divide per trial width counted down from the root. The response
// sits in an output register; a new request is taken once the result has
// moved into it.
module dma_rectangle_divider_search
    import rds_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata,
    rds_req_if.sink         req,
    rds_rsp_if.source       rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MULT = 3'd1;   // count % transfer size
    localparam logic [2:0] S_ROOT = 3'd2;   // floor root, one digit a cycle
    localparam logic [2:0] S_TRY  = 3'd3;   // launch trial division
    localparam logic [2:0] S_WAIT = 3'd4;   // wait for trial result
    localparam logic [2:0] S_FIN  = 3'd5;   // hand result to output register

    logic [2:0]        state_reg,   state_next;
    logic [6:0]        dflt_reg,    dflt_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [ROOT_W-1:0] w_reg,       w_next;
    logic [CNT_W-1:0]  rows_reg,    rows_next;
    logic              ok_reg,      ok_next;

    // floor root working registers
    logic [CNT_W-1:0]  sq_rem_reg,  sq_rem_next;
    logic [CNT_W-1:0]  sq_res_reg,  sq_res_next;
    logic [CNT_W-1:0]  sq_bit_reg,  sq_bit_next;
    logic [CNT_W-1:0]  sq_sum;
    logic              sq_fits;

    // output register
    logic              ov_reg,      ov_next;
    logic [15:0]       owidth_reg,  owidth_next;
    logic [31:0]       orows_reg,   orows_next;
    logic              ofound_reg,  ofound_next;

    logic [6:0]        tsize;
    logic              accept;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    rds_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign tsize     = (req.transfer_bytes == 7'd0) ? dflt_reg : req.transfer_bytes;

    assign sq_sum    = sq_res_reg + sq_bit_reg;
    assign sq_fits   = (sq_rem_reg >= sq_sum);

    always_comb
    begin
        state_next   = state_reg;
        dflt_next    = cfg_we ? cfg_wdata : dflt_reg;
        count_next   = count_reg;
        w_next       = w_reg;
        rows_next    = rows_reg;
        ok_next      = ok_reg;
        sq_rem_next  = sq_rem_reg;
        sq_res_next  = sq_res_reg;
        sq_bit_next  = sq_bit_reg;
        ov_next      = ov_reg && !rsp.ready;
        owidth_next  = owidth_reg;
        orows_next   = orows_reg;
        ofound_next  = ofound_reg;
        div_req.start    = 1'b0;
        div_req.dividend = count_reg;
        div_req.divisor  = CNT_W'(w_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    count_next = req.byte_count[CNT_W-1:0];
                    ok_next    = 1'b0;
                    w_next     = '0;
                    rows_next  = '0;
                    if (tsize == 7'd0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = req.byte_count[CNT_W-1:0];
                        div_req.divisor  = CNT_W'(tsize);
                        state_next       = S_MULT;
                    end
                end
            end
            S_MULT:
            begin
                if (div_rsp.done)
                begin
                    // zero count has no width; a remainder fails the multiple test
                    if (div_rsp.remainder != '0 || count_reg == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        sq_rem_next = count_reg;
                        sq_res_next = '0;
                        sq_bit_next = CNT_W'(1) << ROOT_TOP;
                        state_next  = S_ROOT;
                    end
                end
            end
            S_ROOT:
            begin
                if (sq_fits)
                begin
                    sq_rem_next = sq_rem_reg - sq_sum;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                if (sq_bit_reg[0])
                begin
                    w_next     = sq_res_next[ROOT_W-1:0];
                    state_next = S_TRY;
                end
            end
            S_TRY:
            begin
                div_req.start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        ok_next    = 1'b1;
                        rows_next  = div_rsp.quotient;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        // width one always divides, so this never reaches zero
                        w_next     = w_reg - 1'b1;
                        state_next = S_TRY;
                    end
                end
            end
            S_FIN:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next     = 1'b1;
                    owidth_next = ok_reg ? 16'(w_reg) : 16'd0;
                    orows_next  = ok_reg ? 32'(rows_reg) : 32'd0;
                    ofound_next = ok_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dflt_reg  <= 7'd16;
            ov_reg    <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dflt_reg  <= dflt_next;
            ov_reg    <= ov_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        w_reg      <= w_next;
        rows_reg   <= rows_next;
        sq_rem_reg <= sq_rem_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        owidth_reg <= owidth_next;
        orows_reg  <= orows_next;
        ofound_reg <= ofound_next;
    end

    assign rsp.valid     = ov_reg;
    assign rsp.row_width = owidth_reg;
    assign rsp.row_count = orows_reg;
    assign rsp.found     = ofound_reg;

endmodule

`default_nettype wire

// ===== src/rds_checker.sv =====
// Port-level checks for the rectangle divider search, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none

module rds_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [15:0] rsp_row_width,
    input wire logic [31:0] rsp_row_count,
    input wire logic        rsp_found
);

    // stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_width)
            && $stable(rsp_row_count) && $stable(rsp_found))
        else $error("response word changed while stalled");

    // not found reports all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> rsp_row_width == 16'd0 && rsp_row_count == 32'd0)
        else $error("not-found response with nonzero fields");

    // a found width is never zero and the row count is nonzero
    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_found |-> rsp_row_width != 16'd0 && rsp_row_count != 32'd0)
        else $error("found response with zero width or rows");

    // one request at a time: busy right after accepting
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous one in work");

endmodule

bind dma_rectangle_divider_search rds_checker u_rds_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_row_width (rsp.row_width),
    .rsp_row_count (rsp.row_count),
    .rsp_found     (rsp.found)
);

`default_nettype wire

// ===== tb/tb_dma_rectangle_divider_search.sv =====
// Testbench for dma_rectangle_divider_search: a directed table, then random words
// over several default transfer sizes, each checked by typed layout or in-bench model.
// Depends on rds_pkg, rds_if and the block's top level from src/.

module tb_dma_rectangle_divider_search
    import rds_pkg::*;
();

    // One response word, laid out as the block returns it.
    typedef struct packed {
        logic [15:0] row_width;
        logic [31:0] row_count;
        logic        found;
    } layout_t;

    // Directed table rows: a request word, or a write of the default size.
    typedef enum logic {STEP_WORD, STEP_CFG} step_kind_t;

    // For STEP_CFG rows, xfer carries the new default transfer size.
    typedef struct {
        step_kind_t  kind;
        logic [31:0] count;
        logic [6:0]  xfer;
        bit          typed;
        layout_t     want;
    } dir_row_t;

    localparam int DIR_ROWS    = 23;
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 14;
    // Long sink hold-off: longer than two of the slowest random searches, so the
    // block backs up with one word in its output register and one finished behind it.
    localparam int HOLD_CYCLES = 20000;
    // Idle tail after the last response.
    localparam int TAIL_CYCLES = 200;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;

    rds_req_if req_ch();
    rds_rsp_if rsp_ch();

    dma_rectangle_divider_search DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #5 clk = ~clk;

    // Model copy of the default transfer size register.
    logic [6:0] default_xfer;
    // Layouts still owed by the block, oldest first.
    layout_t    layouts_due [$];
    int         fail_count = 0;
    // Set by the request side; the response side then holds ready low for a while.
    bit         hold_sink = 1'b0;
    // While set, neither side inserts idle cycles.
    bit         no_idle = 1'b0;

    // Floor square root by binary search on the answer; 65535 is the top root of
    // any 32-bit count.
    function automatic logic [31:0] floor_sqrt(input logic [31:0] v);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        lo = 32'd0;
        hi = 32'd65535;
        while (lo < hi)
        begin
            mid = (lo + hi + 32'd1) >> 1;
            if (64'(mid) * 64'(mid) <= 64'(v))
                lo = mid;
            else
                hi = mid - 32'd1;
        end
        return lo;
    endfunction

    // Expected layout of one request word under the current default size.
    function automatic layout_t rect_layout(input logic [31:0] count, input logic [6:0] xfer);
        layout_t     lay;
        logic [31:0] n;
        logic [31:0] w;
        logic [6:0]  eff;
        lay = '0;
        n   = count & 32'((64'd1 << CNT_W) - 64'd1);
        eff = (xfer == 7'd0) ? default_xfer : xfer;
        // Zero effective size or a count that is not a multiple: nothing found.
        if (eff != 7'd0 && n % eff == 0)
        begin
            // Largest divisor not above the root; a zero count never enters the loop.
            for (w = floor_sqrt(n); w != 32'd0; w--)
            begin
                if (n % w == 0)
                begin
                    lay.row_width = w[15:0];
                    lay.row_count = n / w;
                    lay.found     = 1'b1;
                    break;
                end
            end
        end
        return lay;
    endfunction

    // Offer one request word after a random gap and wait for it to be taken.
    // valid stays high afterwards so back-to-back words need no extra edge.
    task automatic send_word(input logic [31:0] count, input logic [6:0] xfer,
                             input bit typed, input layout_t typed_layout);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.byte_count     <= count;
        req_ch.transfer_bytes <= xfer;
        do @(posedge clk); while (!req_ch.ready);
        layouts_due.push_back(typed ? typed_layout : rect_layout(count, xfer));
    endtask

    // Stop offering and wait for every owed response word.
    task automatic drain_words();
        req_ch.valid <= 1'b0;
        while (layouts_due.size() != 0) @(posedge clk);
    endtask

    // Register writes only go in while the block is idle.
    task automatic write_default(input logic [6:0] value);
        drain_words();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        default_xfer = value;
    endtask

    // Request side: reset, directed table, then random phases.
    initial
    begin : stimulus
        dir_row_t     dir_table [DIR_ROWS];
        logic [6:0]   phase_dflt [PHASES];
        logic [31:0]  count;
        logic [31:0]  w;
        logic [63:0]  prod;
        logic [6:0]   xfer;
        logic [6:0]   eff;
        int unsigned  kmax;
        int           pick;

        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.byte_count     <= '0;
        req_ch.transfer_bytes <= '0;
        default_xfer = 7'd16;

        // Typed expectations only where they are obvious; the rest go to the model.
        dir_table = '{
            // zero count with the reset default of 16
            '{STEP_WORD, 32'd0,          7'd0,   1'b1, {16'd0,  32'd0,  1'b0}},
            '{STEP_WORD, 32'd16,         7'd0,   1'b1, {16'd4,  32'd4,  1'b1}},
            // not a multiple of the default
            '{STEP_WORD, 32'd17,         7'd0,   1'b1, {16'd0,  32'd0,  1'b0}},
            '{STEP_WORD, 32'd1,          7'd1,   1'b1, {16'd1,  32'd1,  1'b1}},
            // all ones: the root itself divides
            '{STEP_WORD, 32'hFFFF_FFFF,  7'd1,   1'b0, '0},
            '{STEP_WORD, 32'hFFFF_FFFF,  7'd64,  1'b1, {16'd0,  32'd0,  1'b0}},
            '{STEP_WORD, 32'd4096,       7'd64,  1'b1, {16'd64, 32'd64, 1'b1}},
            // prime below 2^16: search runs all the way down to width 1
            '{STEP_WORD, 32'd65521,      7'd1,   1'b0, '0},
            // largest perfect square
            '{STEP_WORD, 32'hFFFE_0001,  7'd1,   1'b0, '0},
            '{STEP_WORD, 32'd2,          7'd2,   1'b0, '0},
            // transfer sizes above 64 are used as given
            '{STEP_WORD, 32'd16256,      7'd127, 1'b0, '0},
            '{STEP_WORD, 32'd127,        7'd127, 1'b0, '0},
            '{STEP_WORD, 32'd128,        7'd127, 1'b1, {16'd0,  32'd0,  1'b0}},
            // default of zero: zero effective size is never found
            '{STEP_CFG,  32'd0,          7'd0,   1'b0, '0},
            '{STEP_WORD, 32'd64,         7'd0,   1'b1, {16'd0,  32'd0,  1'b0}},
            '{STEP_WORD, 32'd64,         7'd8,   1'b1, {16'd8,  32'd8,  1'b1}},
            '{STEP_CFG,  32'd0,          7'd127, 1'b0, '0},
            '{STEP_WORD, 32'd127,        7'd0,   1'b0, '0},
            '{STEP_WORD, 32'd254,        7'd0,   1'b0, '0},
            '{STEP_CFG,  32'd0,          7'd64,  1'b0, '0},
            '{STEP_WORD, 32'hFFFF_FFC0,  7'd0,   1'b0, '0},
            '{STEP_CFG,  32'd0,          7'd1,   1'b0, '0},
            '{STEP_WORD, 32'hFFFF_FFFF,  7'd0,   1'b0, '0}
        };

        // Default size per random phase: reset value, extremes, zero, overrange, random.
        phase_dflt = '{7'd16, 7'd1, 7'd64, 7'd0, 7'd127, 7'($urandom_range(1, 64))};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
        begin
            if (dir_table[i].kind == STEP_CFG)
                write_default(dir_table[i].xfer);
            else
                send_word(dir_table[i].count, dir_table[i].xfer,
                          dir_table[i].typed, dir_table[i].want);
        end

        // Random words. Counts are shaped so that every search stays short: a random
        // 32-bit count with size 1 could walk the trial loop far down from its root.
        for (int p = 0; p < PHASES; p++)
        begin
            write_default(phase_dflt[p]);
            // one phase runs flat out on both sides
            no_idle = (p == 3);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // long sink hold-off while the request side keeps pushing
                if (p == 0 && n == 4)
                    hold_sink = 1'b1;
                // request side pauses until the block has emptied out
                if (p == 2 && n == 8)
                    drain_words();

                pick = $urandom_range(0, 9);
                xfer = 7'($urandom_range(0, 127));
                eff  = (xfer == 7'd0) ? default_xfer : xfer;
                if (pick < 5 && eff != 7'd0)
                begin
                    // w * (w + 0..2) with w a multiple of the size: root is w, found
                    kmax  = 65535 / eff;
                    w     = eff * $urandom_range(1, kmax);
                    prod  = 64'(w) * 64'(w + $urandom_range(0, 2));
                    count = prod[31:0];
                end
                else if (pick < 7)
                begin
                    // small counts: the trial loop walks far, often down to 1
                    count = $urandom_range(0, 4095);
                    xfer  = 7'($urandom_range(0, 7));
                end
                else if (pick < 8)
                begin
                    // a * (a + up to 400): a couple of hundred trial widths at most
                    xfer  = 7'($urandom_range(1, 8));
                    w     = xfer * $urandom_range(32, 8000);
                    prod  = 64'(w) * 64'(w + $urandom_range(0, 400));
                    count = prod[31:0];
                end
                else
                begin
                    // noise: any count, forced off the multiple of the size
                    xfer  = 7'($urandom_range(2, 127));
                    count = $urandom;
                    if (count % xfer == 0)
                        count = count + 32'd1;
                end
                send_word(count, xfer, 1'b0, '0);
            end
        end

        drain_words();
        // catch any stray word the block might still emit
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** dma_rectangle_divider_search: PASSED **");
        else
            $display("** dma_rectangle_divider_search: FAILED **");
        $finish;
    end

    // Response side: random stalls, one long hold-off on request, and the check
    // of every taken word against the oldest owed layout.
    initial
    begin : response_sink
        int      stall;
        layout_t got;
        layout_t want;

        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                hold_sink = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);

            got.row_width = rsp_ch.row_width;
            got.row_count = rsp_ch.row_count;
            got.found     = rsp_ch.found;
            if (layouts_due.size() == 0)
            begin
                $error("response word with no layout owed: width %0d rows %0d found %0d",
                       got.row_width, got.row_count, got.found);
                fail_count++;
            end
            else
            begin
                want = layouts_due.pop_front();
                if (got.row_width !== want.row_width)
                begin
                    $error("row_width: expected %0d, got %0d", want.row_width, got.row_width);
                    fail_count++;
                end
                if (got.row_count !== want.row_count)
                begin
                    $error("row_count: expected %0d, got %0d", want.row_count, got.row_count);
                    fail_count++;
                end
                if (got.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    fail_count++;
                end
            end
        end
    end

    // Hard stop: several times the slowest expected run.
    initial
    begin : watchdog
        #50_000_000;
        $display("** dma_rectangle_divider_search: FAILED **");
        $finish;
    end

endmodule
